### rtl/core/b64d_pkg.sv
// Package with shared types, status codes and the base64 character map.
package b64d_pkg;

	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned SIX_W    = 6;
	localparam int unsigned ACC_W    = 12;
	localparam int unsigned HELD_W   = 4;
	localparam int unsigned LEN_W    = 8;

	localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 8'd255;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_PAD = 8'h3D;
	localparam logic [BYTE_W-1:0] BYTE_LF  = 8'h0A;
	localparam logic [BYTE_W-1:0] BYTE_CR  = 8'h0D;

	typedef struct packed {
		logic [SIX_W-1:0] value;
		logic             valid;
	} sixbit_t;

	typedef struct packed {
		logic                valid;
		logic [BYTE_W-1:0]   data_byte;
		logic                has_data;
		logic                last;
		logic [STATUS_W-1:0] status;
	} result_t;

	// Maps one character of the standard alphabet to its 6-bit value.
	function automatic sixbit_t sixbit_of(input logic [CHAR_W-1:0] c);
		sixbit_t r;
		r.valid = 1'b1;
		r.value = '0;
		if (c >= "A" && c <= "Z") begin
			r.value = SIX_W'(c - 8'h41);
		end else if (c >= "a" && c <= "z") begin
			r.value = SIX_W'(c - 8'h47);
		end else if (c >= "0" && c <= "9") begin
			r.value = SIX_W'(c + 8'h04);
		end else if (c == "+") begin
			r.value = 6'd62;
		end else if (c == "/") begin
			r.value = 6'd63;
		end else begin
			r.valid = 1'b0;
		end
		return r;
	endfunction

endpackage

### rtl/core/b64d_step.sv
// Per-string decode state and its update for one character.
module b64d_step
	import b64d_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [CHAR_W-1:0]   char_in,
	input  logic                end_of_string,
	input  logic [LEN_W-1:0]    max_length,
	output result_t             result
);

	logic [ACC_W-1:0]  acc_q, acc_d;
	logic [HELD_W-1:0] held_q, held_d;
	logic [LEN_W-1:0]  count_q, count_d;
	logic              halted_q, halted_d;
	logic              trunc_q, trunc_d;
	logic              bad_q, bad_d;
	logic              emitted_q, emitted_d;

	sixbit_t           six;
	logic [HELD_W-1:0] held_sum;
	logic [HELD_W-1:0] shift;
	logic [BYTE_W-1:0] byte_val;
	logic              emit;

	always_comb begin
		six      = sixbit_of(char_in);
		acc_d    = acc_q;
		held_d   = held_q;
		count_d  = count_q;
		halted_d = halted_q;
		trunc_d  = trunc_q;
		bad_d    = bad_q;
		emitted_d = emitted_q;
		emit     = 1'b0;
		held_sum = held_q + HELD_W'(SIX_W);
		shift    = held_sum - HELD_W'(BYTE_W);
		byte_val = '0;
		if (!halted_q) begin
			if (char_in == CHAR_NUL || char_in == CHAR_PAD) begin
				halted_d = 1'b1;
			end else if (!six.valid) begin
				bad_d    = 1'b1;
				halted_d = 1'b1;
			end else begin
				acc_d  = {acc_q[ACC_W-SIX_W-1:0], six.value};
				held_d = held_sum;
				if (held_sum >= HELD_W'(BYTE_W)) begin
					byte_val = BYTE_W'(acc_d >> shift);
					held_d   = shift;
					count_d  = count_q + 1'b1;
					if (!trunc_q) begin
						if (byte_val == BYTE_LF || byte_val == BYTE_CR) begin
							trunc_d = 1'b1;
						end else begin
							emit      = 1'b1;
							emitted_d = 1'b1;
						end
					end
					if (count_d >= max_length) begin
						halted_d = 1'b1;
					end
				end
			end
		end

		result.valid     = emit || end_of_string;
		result.data_byte = emit ? byte_val : '0;
		result.has_data  = emit;
		result.last      = end_of_string;
		result.status    = ST_OK;
		if (end_of_string) begin
			if (bad_d) begin
				result.status = ST_INVALID;
			end else if (!emitted_d) begin
				result.status = ST_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			held_q    <= '0;
			count_q   <= '0;
			halted_q  <= 1'b0;
			trunc_q   <= 1'b0;
			bad_q     <= 1'b0;
			emitted_q <= 1'b0;
		end else if (fire) begin
			if (end_of_string) begin
				acc_q     <= '0;
				held_q    <= '0;
				count_q   <= '0;
				halted_q  <= 1'b0;
				trunc_q   <= 1'b0;
				bad_q     <= 1'b0;
				emitted_q <= 1'b0;
			end else begin
				acc_q     <= acc_d;
				held_q    <= held_d;
				count_q   <= count_d;
				halted_q  <= halted_d;
				trunc_q   <= trunc_d;
				bad_q     <= bad_d;
				emitted_q <= emitted_d;
			end
		end
	end

endmodule

### rtl/core/base64_stream_decoder.sv
// Top level of the streaming base64 decoder: input register, decode step, result register.
// One character beat is accepted per clock; a character that yields a byte or ends a string
// gives its result beat via the input register, decode step and result register; others give
// none. The input register and the result register each hold one beat, so a character is
// taken every cycle as long as the result side does not stall. The final beat of each string
// carries tlast and the string status in tuser. max_length is written through cfg_wen and
// cfg_wdata; the user must do so only while no string is in flight, as the block does not enforce this.
module base64_stream_decoder
	import b64d_pkg::*;
#(
	parameter logic [LEN_W-1:0] MAX_LENGTH_INIT = MAX_LENGTH_RESET
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [LEN_W-1:0]           cfg_wdata,     // max_length
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [CHAR_W-1:0]          s_axis_tdata,  // char_in
	input  logic                       s_axis_tlast,  // end_of_string
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [BYTE_W-1:0]          m_axis_tdata,  // data_byte
	output logic [STATUS_W:0]          m_axis_tuser,  // status[1:0] in bits 2:1, has_data in bit 0
	output logic                       m_axis_tlast   // last
);

	logic [LEN_W-1:0]  max_length_q;
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              advance;
	result_t           step_res;
	result_t           out_s2;

	assign advance       = valid_s1 && (!out_s2.valid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_INIT;
		end else if (cfg_wen) begin
			max_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	b64d_step u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (advance),
		.char_in       (char_s1),
		.end_of_string (last_s1),
		.max_length    (max_length_q),
		.result        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s2 <= '0;
		end else begin
			if (advance) begin
				out_s2.valid <= step_res.valid;
			end else if (m_axis_tready) begin
				out_s2.valid <= 1'b0;
			end
			if (advance && step_res.valid) begin
				out_s2.data_byte <= step_res.data_byte;
				out_s2.has_data  <= step_res.has_data;
				out_s2.last      <= step_res.last;
				out_s2.status    <= step_res.status;
			end
		end
	end

	assign m_axis_tvalid = out_s2.valid;
	assign m_axis_tdata  = out_s2.data_byte;
	assign m_axis_tuser  = {out_s2.status, out_s2.has_data};
	assign m_axis_tlast  = out_s2.last;

endmodule
